// File: hw/rtl/tpss_pkg.sv
// Shared types and constants for the touch packet serial sender.
package tpss_pkg;

    // Phase codes of the transmit sequencer
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_STOP1 = 3'd3;
    localparam logic [2:0] PH_STOP2 = 3'd4;

    // Input kinds carried on tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Packet construction
    localparam logic [7:0] PKT_HEADER = 8'h2A;
    localparam logic [7:0] PKT_BASE   = 8'h30;
    localparam logic [7:0] PKT_TOP    = 8'h07;
    localparam int         POS_SHIFT  = 5;
    localparam int         DATA_BITS  = 8;
    localparam int         PKT_LEN    = 3;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // One result beat
    typedef struct packed {
        logic busy_res;
        logic line_level;
    } tpss_res_t;

endpackage

// File: hw/rtl/tpss_core.sv
// Transmit sequencer: packet store, phase/bit/byte counters and line register.
module tpss_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  logic                item_op,
    input  logic [7:0]          item_x,
    input  logic [7:0]          item_y,
    output tpss_pkg::tpss_res_t item_res
);
    import tpss_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [1:0] byte_index_reg, byte_index_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic       line_reg, line_next;
    logic [7:0] packet_bytes_reg [PKT_LEN];
    logic [7:0] cur_byte;
    logic [1:0] byte_inc;
    logic [3:0] bit_inc;

    // Select the byte on the line; out-of-range index reads as zero
    always_comb begin
        cur_byte = 8'h00;
        if (byte_index_reg < 2'(PKT_LEN)) begin
            cur_byte = packet_bytes_reg[byte_index_reg];
        end
    end

    assign byte_inc = byte_index_reg + 2'd1;
    assign bit_inc  = bit_index_reg + 4'd1;

    // Advance the sequencer by one beat
    always_comb begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        bit_index_next  = bit_index_reg;
        line_next       = line_reg;
        if (item_op == OP_PRESS) begin
            byte_index_next = 2'd0;
            phase_next      = PH_START;
        end else begin
            case (phase_reg)
                PH_START: begin
                    bit_index_next = 4'd0;
                    line_next      = 1'b0;
                    phase_next     = PH_DATA;
                end
                PH_DATA: begin
                    line_next      = cur_byte[bit_index_reg[2:0]];
                    bit_index_next = bit_inc;
                    if (bit_inc >= 4'(DATA_BITS)) begin
                        phase_next = PH_STOP1;
                    end
                end
                PH_STOP1: begin
                    line_next  = 1'b1;
                    phase_next = PH_STOP2;
                end
                PH_STOP2: begin
                    line_next       = 1'b1;
                    byte_index_next = byte_inc;
                    if (byte_inc == 2'(PKT_LEN) || byte_inc == 2'd0) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_START;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_index_reg <= 2'd0;
            bit_index_reg  <= 4'd0;
            line_reg       <= 1'b1;
        end else if (item_valid) begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            bit_index_reg  <= bit_index_next;
            line_reg       <= line_next;
        end
    end

    // Latch the packet on a press
    always_ff @(posedge aclk) begin
        if (item_valid && item_op == OP_PRESS) begin
            packet_bytes_reg[0] <= PKT_HEADER;
            packet_bytes_reg[1] <= PKT_BASE + PKT_TOP - 8'(item_y >> POS_SHIFT);
            packet_bytes_reg[2] <= PKT_BASE + 8'(item_x >> POS_SHIFT);
        end
    end

    // Result of this beat
    assign item_res.line_level = line_next;
    assign item_res.busy_res   = (phase_next >= PH_START) && (phase_next <= PH_STOP2);

endmodule

// File: hw/rtl/tpss_out_buf.sv
// Result register with a skid stage so input acceptance waits only when both hold finished beats.
module tpss_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tpss_pkg::tpss_res_t push_res,
    output logic                push_ready,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tpss_pkg::tpss_res_t pop_res
);
    import tpss_pkg::*;

    logic      main_valid_reg;
    logic      skid_valid_reg;
    tpss_res_t main_res_reg;
    tpss_res_t skid_res_reg;
    logic      pop;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_res    = main_res_reg;
    assign pop        = main_valid_reg && pop_ready;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_res_reg <= skid_res_reg;
            end else begin
                main_res_reg <= push_res;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_res_reg <= push_res;
            end else begin
                main_res_reg <= push_res;
            end
        end
    end

endmodule

// File: hw/rtl/touch_packet_serial_sender_unit.sv
// Each accepted beat's result is registered in the result buffer before it reaches the master side.
// Throughput: one beat per cycle while s_tready is high; the sequencer updates in a single pass per beat.
// A two-entry result buffer keeps s_tready high while one finished beat waits.
// Reset (aresetn low, synchronous): line high, sequencer idle, result buffer empty.
// The packet store has no reset; it is written by the first press.
module touch_packet_serial_sender_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tpss_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] touch_x, [15:8] touch_y
    input  logic                               s_tuser,  // [0] op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpss_pkg::OUT_DATA_W-1:0]    m_tdata   // [0] line_level, [1] busy_res
);
    import tpss_pkg::*;

    logic      accept;
    tpss_res_t core_res;
    tpss_res_t out_res;

    assign accept = s_tvalid && s_tready;

    // Sequencer
    tpss_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item_op    (s_tuser),
        .item_x     (s_tdata[7:0]),
        .item_y     (s_tdata[15:8]),
        .item_res   (core_res)
    );

    // Result buffer
    tpss_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_res   (core_res),
        .push_ready (s_tready),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_res    (out_res)
    );

    assign m_tdata = {6'b0, out_res.busy_res, out_res.line_level};

endmodule
